// File: rtl/core/gb3_pkg.sv
// Shared types and fixed constants for the 3x3 Gaussian blur stream.
// No dependencies; gb3_kernel, gb3_out_fifo and the top level refer to it by scoped names.
package gb3_pkg;

  // Width of the image_side configuration register.
  localparam int SIDE_BITS  = 13;
  // Reset value of image_side and its lower clamp bound.
  localparam int SIDE_RESET = 4096;
  localparam int SIDE_MIN   = 3;
  // Width of the row and column fields of a result.
  localparam int POS_BITS   = 12;
  // Results one input pixel can produce at most.
  localparam int MAX_RES    = 3;
  localparam int RES_CNT_BITS = 2;
  // Result queue geometry.
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = 3;
  localparam int FIFO_CNT_BITS = 4;

  // Position and end-of-frame marker of one result.
  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                done;
  } gb3_meta_t;

  // Control of the pixel in the kernel stage, decoded from the counters.
  typedef struct packed {
    logic                valid;     // a pixel is in the stage
    logic                has_delay; // row >= 1 and col >= 1
    logic                last_col;  // col == side-1
    logic                last_row;  // row == side-1
    logic                border;    // delayed output lies on the first row or column
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
  } gb3_stage_t;

endpackage

// File: rtl/core/gb3_pix_if.sv
// Input pixel channel: valid/ready handshake carrying one raster pixel.
// No dependencies.
interface gb3_pix_if #(
  parameter int PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: rtl/core/gb3_res_if.sv
// Result channel: valid/ready handshake carrying a pixel and its position.
// No dependencies.
interface gb3_res_if #(
  parameter int PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic [11:0]           out_row;
  logic [11:0]           out_col;
  logic                  frame_done;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output frame_done, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input frame_done, output ready);
endinterface

// File: rtl/core/gb3_line_ram.sv
// Line store: one synchronous memory holding rows r-2 and r-1 side by side.
// One write and one read port, read data registered. No dependencies.
module gb3_line_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/gb3_kernel.sv
// Kernel stage: 3x2 window, 1-2-1 x 1-2-1 weighted sum and result selection.
// Depends on gb3_pkg.
module gb3_kernel #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gb3_pkg::gb3_stage_t          ctrl_i,
  input  logic [PIXEL_BITS-1:0]        pix_i,
  input  logic [PIXEL_BITS-1:0]        older_i,
  input  logic [PIXEL_BITS-1:0]        prev_i,
  output logic [PIXEL_BITS-1:0]        res_pix_o  [gb3_pkg::MAX_RES],
  output gb3_pkg::gb3_meta_t           res_meta_o [gb3_pkg::MAX_RES],
  output logic [gb3_pkg::RES_CNT_BITS-1:0] res_cnt_o
);

  localparam int SumBits = PIXEL_BITS + 4;

  // win_q[k][0] holds column c-2, win_q[k][1] column c-1; k = 0 is row r-2.
  logic [PIXEL_BITS-1:0] win_q [3][2];
  logic [PIXEL_BITS-1:0] col   [3];
  logic [SumBits-1:0]    sum;
  logic [PIXEL_BITS-1:0] delay_pix;
  logic [gb3_pkg::POS_BITS-1:0] orow;
  logic [gb3_pkg::POS_BITS-1:0] ocol;
  logic [1:0]            last_idx;

  assign col[0] = older_i;
  assign col[1] = prev_i;
  assign col[2] = pix_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= '0;
        win_q[k][1] <= '0;
      end
    end else if (ctrl_i.valid) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= col[k];
      end
    end
  end

  always_comb begin
    sum = SumBits'(win_q[0][0]) + SumBits'(col[0]) + SumBits'(win_q[2][0])
        + SumBits'(col[2])
        + ((SumBits'(win_q[0][1]) + SumBits'(win_q[1][0]) + SumBits'(col[1])
            + SumBits'(win_q[2][1])) << 1)
        + (SumBits'(win_q[1][1]) << 2);
    delay_pix = ctrl_i.border ? win_q[1][1] : sum[SumBits-1:4];
  end

  assign orow = ctrl_i.row - gb3_pkg::POS_BITS'(1);
  assign ocol = ctrl_i.col - gb3_pkg::POS_BITS'(1);

  always_comb begin
    for (int k = 0; k < gb3_pkg::MAX_RES; k++) begin
      res_pix_o[k]  = '0;
      res_meta_o[k] = '0;
    end
    res_cnt_o = '0;
    last_idx  = 2'd0;
    if (ctrl_i.valid) begin
      if (ctrl_i.has_delay) begin
        res_pix_o[0]  = delay_pix;
        res_meta_o[0] = '{row: orow, col: ocol, done: 1'b0};
        last_idx      = 2'd1;
        if (ctrl_i.last_col) begin
          // Right border of the previous row is a plain copy.
          res_pix_o[1]  = prev_i;
          res_meta_o[1] = '{row: orow, col: ctrl_i.col, done: 1'b0};
          last_idx      = 2'd2;
        end
      end
      res_cnt_o = last_idx;
      if (ctrl_i.last_row) begin
        res_pix_o[last_idx]  = pix_i;
        res_meta_o[last_idx] = '{row: ctrl_i.row, col: ctrl_i.col, done: ctrl_i.last_col};
        res_cnt_o            = last_idx + 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/gb3_out_fifo.sv
// Result queue: takes up to three results per cycle, hands out one per cycle while ready_i is high.
// Depends on gb3_pkg.
module gb3_out_fifo #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [gb3_pkg::RES_CNT_BITS-1:0]  push_cnt_i,
  input  logic [PIXEL_BITS-1:0]             push_pix_i  [gb3_pkg::MAX_RES],
  input  gb3_pkg::gb3_meta_t                push_meta_i [gb3_pkg::MAX_RES],
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [PIXEL_BITS-1:0]             pix_o,
  output gb3_pkg::gb3_meta_t                meta_o,
  output logic [gb3_pkg::FIFO_CNT_BITS-1:0] count_o
);

  localparam int PtrBits = gb3_pkg::FIFO_PTR_BITS;
  localparam int CntBits = gb3_pkg::FIFO_CNT_BITS;

  logic [PIXEL_BITS-1:0] pix_q  [gb3_pkg::FIFO_DEPTH];
  gb3_pkg::gb3_meta_t    meta_q [gb3_pkg::FIFO_DEPTH];
  logic [PtrBits-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]    count_q, count_d;
  logic                  pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign pix_o   = pix_q[rd_ptr_q];
  assign meta_o  = meta_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrBits'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrBits'(pop);
    count_d  = count_q + CntBits'(push_cnt_i) - CntBits'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < gb3_pkg::MAX_RES; k++) begin
      if (k < int'(push_cnt_i)) begin
        pix_q[wr_ptr_q + PtrBits'(k)]  <= push_pix_i[k];
        meta_q[wr_ptr_q + PtrBits'(k)] <= push_meta_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/core/gaussian_blur_3x3_stream.sv
// Top level of the streaming 3x3 Gaussian blur: counters, line RAM, kernel, result queue.
// Depends on gb3_pkg, gb3_pix_if, gb3_res_if, gb3_line_ram, gb3_kernel, gb3_out_fifo.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+------------------------------------------
//   pix_i     | in  | valid/ready   | pixel_in
//   res_o     | out | valid/ready   | pixel_out, out_row, out_col, frame_done
//   cfg       | in  | cfg_we_i only | cfg_wdata_i = image_side
//
// One pixel is accepted per clock while pix_i.ready is high. A transaction on pix_i
// presents its column to the line RAM read port, and the pixel sits in the kernel
// stage during the next cycle with the read data; its results enter the result
// queue at the end of that cycle. The sustained rate is set by the single read and
// single write port of the line RAM, which serve one pixel per cycle.
// Row ends and the last row produce two results per pixel, the final pixel of a frame
// three; these bursts fill the
// eight-entry result queue, and pix_i.ready drops while fewer than three slots
// remain beyond what the kernel stage is about to write. Reset clears the counters,
// the window and the queue; the line RAM needs no clearing pass, since entries
// not yet written never reach an output.
module gaussian_blur_3x3_stream #(
  parameter int MAX_SIDE   = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gb3_pkg::SIDE_BITS-1:0] cfg_wdata_i,
  gb3_pix_if.sink                       pix_i,
  gb3_res_if.source                     res_o
);

  // Counter and RAM address width.
  localparam int CntW = $clog2(MAX_SIDE);
  localparam int ExtW = gb3_pkg::SIDE_BITS + 1;
  // The reset side is 4096, clamped to what the line RAM can hold.
  localparam int ResetSide = (gb3_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE
                                                              : gb3_pkg::SIDE_RESET;
  localparam int QueueRoom = gb3_pkg::FIFO_DEPTH - gb3_pkg::MAX_RES;

  // Last valid index (side - 1) of the clamped side.
  logic [CntW-1:0] last_q, last_d;
  // Position of the next input pixel.
  logic [CntW-1:0] row_q, row_d, col_q, col_d;

  gb3_pkg::gb3_stage_t   stage_q, stage_d;
  logic [PIXEL_BITS-1:0] stage_pix_q;
  logic [CntW-1:0]       stage_addr_q;

  logic                  accept;
  logic [ExtW-1:0]       side_ext;
  logic [2*PIXEL_BITS-1:0] ram_rdata;
  logic [PIXEL_BITS-1:0] older_pix, prev_pix;

  logic [PIXEL_BITS-1:0]                 res_pix  [gb3_pkg::MAX_RES];
  gb3_pkg::gb3_meta_t                    res_meta [gb3_pkg::MAX_RES];
  logic [gb3_pkg::RES_CNT_BITS-1:0]      res_cnt;
  logic [gb3_pkg::FIFO_CNT_BITS-1:0]     q_count;
  logic [gb3_pkg::FIFO_CNT_BITS:0]       q_need;
  logic [PIXEL_BITS-1:0]                 q_pix;
  gb3_pkg::gb3_meta_t                    q_meta;

  // ---------------------------------------------------------------------------
  // Configuration: clamp the side to [3, MAX_SIDE] once, when it is written, and
  // keep only side - 1 for the end-of-row and end-of-frame compares.
  // ---------------------------------------------------------------------------
  always_comb begin
    side_ext = ExtW'(cfg_wdata_i);
    if (side_ext < ExtW'(gb3_pkg::SIDE_MIN)) begin
      last_d = CntW'(gb3_pkg::SIDE_MIN - 1);
    end else if (side_ext > ExtW'(MAX_SIDE)) begin
      last_d = CntW'(MAX_SIDE - 1);
    end else begin
      last_d = CntW'(side_ext - ExtW'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: the queue must have room for the worst case of the pixel now in
  // the kernel stage plus the one about to enter it. No path runs from
  // res_o.ready to pix_i.ready.
  // ---------------------------------------------------------------------------
  assign q_need      = (gb3_pkg::FIFO_CNT_BITS+1)'(q_count)
                     + (gb3_pkg::FIFO_CNT_BITS+1)'(res_cnt);
  assign pix_i.ready = (q_need <= (gb3_pkg::FIFO_CNT_BITS+1)'(QueueRoom));
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      // A new side restarts the frame.
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (col_q == last_q) begin
        col_d = '0;
        row_d = (row_q == last_q) ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  always_comb begin
    stage_d.valid     = accept;
    stage_d.has_delay = (row_q != '0) && (col_q != '0);
    stage_d.last_col  = (col_q == last_q);
    stage_d.last_row  = (row_q == last_q);
    stage_d.border    = (row_q == CntW'(1)) || (col_q == CntW'(1));
    stage_d.row       = gb3_pkg::POS_BITS'(row_q);
    stage_d.col       = gb3_pkg::POS_BITS'(col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= CntW'(ResetSide - 1);
      row_q   <= '0;
      col_q   <= '0;
      stage_q <= '0;
    end else begin
      if (cfg_we_i) begin
        last_q <= last_d;
      end
      row_q   <= row_d;
      col_q   <= col_d;
      stage_q <= stage_d;
    end
  end

  // Payload of the kernel stage needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_pix_q  <= pix_i.pixel_in;
      stage_addr_q <= col_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Line RAM: each entry holds {row r-2, row r-1} for one column. A pixel reads its
  // column on acceptance and writes it back in the next cycle with {row r-1, itself}.
  // The write always targets the column before the one being read, and the side is
  // at least three, so a read never meets a pending write to the same entry.
  // ---------------------------------------------------------------------------
  gb3_line_ram #(
    .DEPTH (MAX_SIDE),
    .WIDTH (2 * PIXEL_BITS)
  ) u_gb3_line_ram (
    .clk_i   (clk_i),
    .we_i    (stage_q.valid),
    .waddr_i (stage_addr_q),
    .wdata_i ({prev_pix, stage_pix_q}),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign older_pix = ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign prev_pix  = ram_rdata[PIXEL_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Kernel stage: the pixel for (r-1, c-1) leaves here, followed by the right
  // border copy at a row end and by the pixel's own copy on the last row.
  // ---------------------------------------------------------------------------
  gb3_kernel #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_gb3_kernel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (stage_q),
    .pix_i      (stage_pix_q),
    .older_i    (older_pix),
    .prev_i     (prev_pix),
    .res_pix_o  (res_pix),
    .res_meta_o (res_meta),
    .res_cnt_o  (res_cnt)
  );

  // ---------------------------------------------------------------------------
  // Result queue: decouples the output transaction from the input side.
  // ---------------------------------------------------------------------------
  gb3_out_fifo #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_gb3_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push_pix_i  (res_pix),
    .push_meta_i (res_meta),
    .valid_o     (res_o.valid),
    .ready_i     (res_o.ready),
    .pix_o       (q_pix),
    .meta_o      (q_meta),
    .count_o     (q_count)
  );

  assign res_o.pixel_out  = q_pix;
  assign res_o.out_row    = q_meta.row;
  assign res_o.out_col    = q_meta.col;
  assign res_o.frame_done = q_meta.done;

endmodule

// File: rtl/core/gb3_checker.sv
// Port-level checks of the blur stream's result channel, bound to the top level.
// Depends on gaussian_blur_3x3_stream and its interfaces.
module gb3_checker #(
  parameter int PIXEL_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic [PIXEL_BITS-1:0] pixel_out_i,
  input logic [11:0]           out_row_i,
  input logic [11:0]           out_col_i,
  input logic                  frame_done_i
);

  logic res_accept;
  // Set while the next result transaction must be the first of a frame.
  logic frame_start_q;

  assign res_accept = res_valid_i && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= 1'b1;
    end else if (cfg_we_i) begin
      frame_start_q <= 1'b1;
    end else if (res_accept) begin
      frame_start_q <= frame_done_i;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(pixel_out_i) && $stable(out_row_i)
      && $stable(out_col_i) && $stable(frame_done_i))
    else $error("result payload changed while stalled");

  a_done_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && frame_done_i |-> out_row_i == out_col_i && out_row_i != 12'd0)
    else $error("frame_done on a pixel off the bottom-right corner");

  a_frame_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_accept && frame_start_q && !cfg_we_i |-> out_row_i == 12'd0 && out_col_i == 12'd0)
    else $error("first result of a frame is not at row 0, column 0");

endmodule

bind gaussian_blur_3x3_stream gb3_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_gb3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .pixel_out_i  (res_o.pixel_out),
  .out_row_i    (res_o.out_row),
  .out_col_i    (res_o.out_col),
  .frame_done_i (res_o.frame_done)
);
